// File: rtl/bost_pkg.sv
// Shared types and codes for the bounded ordered set table.
package bost_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] value;
      logic [3:0]  index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  position;
      logic [31:0] read_value;
      logic [4:0]  entry_count;
      logic        is_full;
      logic        is_empty;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       add_write;
      logic       read_issue;
      logic       scan_start;
      logic       scan_step;
      logic       shift_start;
      logic       shift_step;
      logic       count_dec;
      logic       respond;
      logic [2:0] rsp_status;
      logic       rsp_pos_count;
      logic       rsp_pos_hit;
      logic       rsp_read_data;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] req_cmd;
      logic       full;
      logic       empty;
      logic       idx_ok;
      logic       scan_hit;
      logic       scan_miss;
      logic       shift_done;
   } dp_status_type;

endpackage

// File: rtl/bost_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bost_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bost_ctrl.sv
// Command sequencer for the bounded ordered set table.
module bost_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bost_pkg::dp_status_type dp_status,
   output bost_pkg::ctl_cmd_type   ctl_cmd
);
   import bost_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      ctl_cmd.rsp_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl_cmd.capture = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (dp_status.req_cmd)
               CMD_ADD: begin
                  ctl_cmd.respond = 1'b1;
                  state_in = S_IDLE;
                  if (dp_status.full) begin
                     ctl_cmd.rsp_status = ST_FULL;
                  end else begin
                     ctl_cmd.add_write     = 1'b1;
                     ctl_cmd.rsp_pos_count = 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (dp_status.empty) begin
                     ctl_cmd.respond    = 1'b1;
                     ctl_cmd.rsp_status = ST_EMPTY;
                     state_in = S_IDLE;
                  end else begin
                     ctl_cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               CMD_FIND: begin
                  ctl_cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
               CMD_READ: begin
                  if (dp_status.idx_ok) begin
                     ctl_cmd.read_issue = 1'b1;
                     state_in = S_READ;
                  end else begin
                     ctl_cmd.respond    = 1'b1;
                     ctl_cmd.rsp_status = ST_BAD_INDEX;
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            ctl_cmd.respond       = 1'b1;
            ctl_cmd.rsp_read_data = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            ctl_cmd.scan_step = 1'b1;
            if (dp_status.scan_hit) begin
               if (dp_status.req_cmd == CMD_REMOVE) begin
                  ctl_cmd.shift_start = 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  ctl_cmd.respond     = 1'b1;
                  ctl_cmd.rsp_pos_hit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (dp_status.scan_miss) begin
               ctl_cmd.respond    = 1'b1;
               ctl_cmd.rsp_status = ST_NOT_FOUND;
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            ctl_cmd.shift_step = 1'b1;
            if (dp_status.shift_done) begin
               ctl_cmd.count_dec = 1'b1;
               ctl_cmd.respond   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/bost_dp.sv
// Datapath of the bounded ordered set table: entry store, count, scan and shift pointers.
module bost_dp #(
   parameter int MAX_ENTRIES = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bost_pkg::req_type       req_payload,
   input  bost_pkg::ctl_cmd_type   ctl_cmd,
   output bost_pkg::dp_status_type dp_status,
   output logic                    rsp_strobe,
   output bost_pkg::rsp_type       rsp_payload
);
   import bost_pkg::*;

   localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int IdxW = AW + 4;
   localparam int PosW = CW + 4;

   logic [1:0]             cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [3:0]             idx_ff, idx_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]          ptr_dec;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic [AW-1:0]          wr_addr_ff, wr_addr_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   logic [63:0]            val_wide;
   logic [IdxW-1:0]        idx_ext;
   logic                   more;
   logic                   issue;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic [AW-1:0]          ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   logic [PosW-1:0]        pos_wide;
   logic [PosW-1:0]        cnt_wide;
   logic [63:0]            rd_wide;

   assign val_wide = 64'(req_payload.value);
   assign idx_ext  = IdxW'(idx_ff);
   assign more     = (rd_ptr_ff < count_ff);
   assign issue    = (ctl_cmd.scan_step | ctl_cmd.shift_step) & more;
   assign ptr_dec  = rd_ptr_ff - CW'(1);

   assign ram_wr_en   = ctl_cmd.add_write | (ctl_cmd.shift_step & wr_pend_ff);
   assign ram_wr_addr = ctl_cmd.add_write ? count_ff[AW-1:0] : wr_addr_ff;
   assign ram_wr_data = ctl_cmd.add_write ? key_ff : ram_rd_data;
   assign ram_rd_addr = ctl_cmd.read_issue ? idx_ext[AW-1:0] : rd_ptr_ff[AW-1:0];

   bost_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      cmd_in = cmd_ff;
      key_in = key_ff;
      idx_in = idx_ff;
      if (ctl_cmd.capture) begin
         cmd_in = req_payload.cmd;
         key_in = val_wide[VALUE_WIDTH-1:0];
         idx_in = req_payload.index;
      end

      priority if (ctl_cmd.add_write) begin
         count_in = count_ff + CW'(1);
      end else if (ctl_cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end

      priority if (ctl_cmd.scan_start) begin
         rd_ptr_in = '0;
      end else if (ctl_cmd.shift_start) begin
         rd_ptr_in = CW'(cmp_idx_ff) + CW'(1);
      end else if (issue) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
      end else begin
         rd_ptr_in = rd_ptr_ff;
      end

      cmp_valid_in = ctl_cmd.scan_step & issue & ~ctl_cmd.shift_start;
      cmp_idx_in   = (ctl_cmd.scan_step & issue) ? rd_ptr_ff[AW-1:0] : cmp_idx_ff;
      wr_pend_in   = ctl_cmd.shift_step & issue;
      wr_addr_in   = (ctl_cmd.shift_step & issue) ? ptr_dec[AW-1:0] : wr_addr_ff;
   end

   always_comb begin
      pos_wide = '0;
      if (ctl_cmd.rsp_pos_count) begin
         pos_wide = PosW'(count_ff);
      end else if (ctl_cmd.rsp_pos_hit) begin
         pos_wide = PosW'(cmp_idx_ff);
      end
      rd_wide  = ctl_cmd.rsp_read_data ? 64'(ram_rd_data) : 64'(0);
      cnt_wide = PosW'(count_in);

      rsp_in.status      = ctl_cmd.rsp_status;
      rsp_in.position    = pos_wide[3:0];
      rsp_in.read_value  = rd_wide[31:0];
      rsp_in.entry_count = cnt_wide[4:0];
      rsp_in.is_full     = (count_in == CW'(MAX_ENTRIES));
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= ctl_cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      rd_ptr_ff  <= rd_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      wr_addr_ff <= wr_addr_in;
      if (ctl_cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dp_status.req_cmd    = cmd_ff;
   assign dp_status.full       = (count_ff == CW'(MAX_ENTRIES));
   assign dp_status.empty      = (count_ff == '0);
   assign dp_status.idx_ok     = (32'(idx_ff) < 32'(count_ff));
   assign dp_status.scan_hit   = cmp_valid_ff && (ram_rd_data == key_ff);
   assign dp_status.scan_miss  = !cmp_valid_ff && !more;
   assign dp_status.shift_done = !wr_pend_ff && !more;

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/bounded_ordered_set_table_core.sv
// Bounded ordered set table: packed value list with add, remove, find and indexed read.
//
// A command beat is taken at a rising edge where start is high and busy is low;
// req_payload carries cmd, value and index. Exactly one result beat follows on
// rsp_payload, marked by rsp_strobe for a single cycle. The receiver cannot hold
// a result off, and the block takes no new beat until the result has appeared.
// Add and every rejected command respond from the execute state; a good read
// responds from the read state after the RAM access. Find and remove walk the
// stored entries through the single read port of the entry RAM, one entry per
// cycle, stopping at the first match or at the entry count; remove then adds a
// shift pass that moves each entry behind the match down by one, one per cycle.
// Reset empties the table by clearing the count; the RAM is not cleared, since
// only slots below the count are ever read.
module bounded_ordered_set_table_core #(
   parameter int MAX_ENTRIES = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bost_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output bost_pkg::rsp_type rsp_payload
);
   import bost_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   bost_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd)
   );

   bost_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl_cmd     (ctl_cmd),
      .dp_status   (dp_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result beat while a command is still in progress.");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two result beats in a row.");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status == ST_FULL) |-> rsp_payload.is_full)
      else $error("Full status without the full flag.");

   a_add_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.add_write |-> !dp_status.full)
      else $error("Entry written while the table is full.");
`endif

endmodule
